>>> hw/rtl/sbf_pkg.sv
package sbf_pkg;

  // default storage limits, handed to the top level as parameters
  localparam int MaxWidthDef    = 1024;
  localparam int MaxChannelsDef = 4;

  // fixed geometry limits of the register fields
  localparam int MaxHeight = 4096;
  localparam int MinWidth  = 2;
  localparam int MinHeight = 2;

  // field widths
  localparam int SampleW  = 8;
  localparam int WidthW   = 11;
  localparam int HeightW  = 13;
  localparam int ChanW    = 3;
  localparam int WeightW  = 7;
  localparam int RowW     = 12;
  localparam int CfgDataW = 13;
  localparam int CfgIdxW  = 2;

  // arithmetic constants
  localparam int SharpGain   = 5;
  localparam int SampleMax   = 255;
  localparam int PercentFull = 100;
  localparam int BlendW      = 15;
  // floor(x / 100) == (x * Div100Mul) >> Div100Shift for x below 43690
  localparam int Div100Mul   = 5243;
  localparam int Div100Shift = 19;
  localparam int Div100MulW  = 13;

  // line store banking: a row position p lives in bank p mod 5, so that
  // p - c, p and p + c land in three different banks for any c in 1..4
  localparam int NumBanks = 5;
  localparam int BankW    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1,
    CfgChannels    = 2'd2,
    CfgWeight      = 2'd3
  } cfg_idx_e;

endpackage

>>> hw/rtl/sbf_ram.sv
module sbf_ram #(
  parameter int Depth = 2,
  parameter int Width = 8,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> hw/rtl/sharpen_and_blend_filter_unit.sv
// path: each accepted sample goes through the stage 1, stage 2 and output registers in order
// throughput: one sample per cycle while the output is ready; in the last row each sample
//   gives two results, so there the single output port holds the input back
// reset: position counters clear, registers return to width 2, height 2, 3 channels,
//   weight 0; the line store is not cleared and needs no clearing pass
module sharpen_and_blend_filter_unit import sbf_pkg::*; #(
  parameter int MaxWidth    = MaxWidthDef,
  parameter int MaxChannels = MaxChannelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // sample input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SampleW-1:0]  sample_in_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SampleW-1:0]  sample_out_o,
  output logic                frame_end_o,
  output logic                run_last_o
);

  // one row of interleaved samples, and the shape of a bank
  localparam int RowSpan   = MaxWidth * MaxChannels;
  localparam int ColW      = (RowSpan > 1) ? $clog2(RowSpan) : 1;
  localparam int StrideW   = $clog2(RowSpan + 1);
  localparam int BankDepth = (RowSpan + NumBanks - 1) / NumBanks;
  localparam int Aw        = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int ProdW     = WidthW + ChanW;
  localparam int Div100W   = BlendW + Div100MulW;

  // ---------------------------------------------------------------------------
  // configuration registers, always ready
  // ---------------------------------------------------------------------------
  logic [WidthW-1:0]  cfg_width_q;
  logic [HeightW-1:0] cfg_height_q;
  logic [ChanW-1:0]   cfg_chan_q;
  logic [WeightW-1:0] cfg_weight_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WidthW'(MinWidth);
      cfg_height_q <= HeightW'(MinHeight);
      cfg_chan_q   <= ChanW'(3);
      cfg_weight_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgImageWidth:  cfg_width_q  <= cfg_data_i[WidthW-1:0];
        CfgImageHeight: cfg_height_q <= cfg_data_i[HeightW-1:0];
        CfgChannels:    cfg_chan_q   <= cfg_data_i[ChanW-1:0];
        CfgWeight:      cfg_weight_q <= cfg_data_i[WeightW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: out-of-range values saturate to the used ranges
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic [ChanW-1:0]   c_eff;
  logic [WeightW-1:0] wgt_eff;
  logic [ProdW-1:0]   stride_prod;
  logic [StrideW-1:0] stride;

  always_comb begin
    if (cfg_width_q < WidthW'(MinWidth)) begin
      w_eff = WidthW'(MinWidth);
    end else if (ProdW'(cfg_width_q) > ProdW'(MaxWidth)) begin
      w_eff = WidthW'(MaxWidth);
    end else begin
      w_eff = cfg_width_q;
    end

    if (cfg_height_q < HeightW'(MinHeight)) begin
      h_eff = HeightW'(MinHeight);
    end else if (cfg_height_q > HeightW'(MaxHeight)) begin
      h_eff = HeightW'(MaxHeight);
    end else begin
      h_eff = cfg_height_q;
    end

    if (cfg_chan_q == '0) begin
      c_eff = ChanW'(1);
    end else if (cfg_chan_q > ChanW'(MaxChannels)) begin
      c_eff = ChanW'(MaxChannels);
    end else begin
      c_eff = cfg_chan_q;
    end

    wgt_eff = (cfg_weight_q > WeightW'(PercentFull)) ? WeightW'(PercentFull) : cfg_weight_q;

    stride_prod = ProdW'(w_eff) * ProdW'(c_eff);
    stride      = StrideW'(stride_prod);
  end

  // ---------------------------------------------------------------------------
  // pipeline control: each stage moves on when the one after it frees up
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q;
  logic pend0_q, pend1_q;   // output register: blended result, last-row echo
  logic out_fire, in_fire;
  logic free1, free2, free3;

  assign out_valid_o = pend0_q || pend1_q;
  assign out_fire    = out_valid_o && out_ready_i;
  assign free3       = !out_valid_o || (out_fire && !(pend0_q && pend1_q));
  assign free2       = !v2_q || free3;
  assign free1       = !v1_q || free2;
  assign in_ready_o  = free1;
  assign in_fire     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // position counters; the column is also kept as (col / 5, col mod 5)
  // ---------------------------------------------------------------------------
  logic [ColW-1:0]  col_q, col_d;
  logic [Aw-1:0]    bq_q, bq_d;
  logic [BankW-1:0] br_q, br_d;
  logic [RowW-1:0]  row_q, row_d;

  // position of the current sample after the geometry check
  logic             wrap_pre;
  logic [RowW:0]    row_pre;
  logic [RowW-1:0]  row_c;
  logic [ColW-1:0]  col_c;
  logic [Aw-1:0]    q_c, q_l, q_r;
  logic [BankW-1:0] r_c, r_l, r_r;
  logic [BankW:0]   r_lsum, r_rsum;
  logic [StrideW-1:0] col_ext, col_inc;
  logic [RowW:0]    row_inc;
  logic             interior_c, emit0_c, emit1_c, fe_c;

  always_comb begin
    // a row or frame that shrank under the counters restarts them
    wrap_pre = StrideW'(col_q) >= stride;
    row_pre  = wrap_pre ? ({1'b0, row_q} + (RowW+1)'(1)) : {1'b0, row_q};
    row_c    = (HeightW'(row_pre) >= h_eff) ? '0 : row_pre[RowW-1:0];
    col_c    = wrap_pre ? '0 : col_q;
    q_c      = wrap_pre ? '0 : bq_q;
    r_c      = wrap_pre ? '0 : br_q;

    // left neighbour, one pixel back
    r_lsum = {1'b0, r_c} + (BankW+1)'(NumBanks) - {1'b0, c_eff};
    if (r_c >= c_eff) begin
      r_l = r_c - c_eff;
      q_l = q_c;
    end else begin
      r_l = r_lsum[BankW-1:0];
      q_l = q_c - Aw'(1);
    end

    // right neighbour, one pixel ahead
    r_rsum = {1'b0, r_c} + {1'b0, c_eff};
    if (r_rsum >= (BankW+1)'(NumBanks)) begin
      r_r = BankW'(r_rsum - (BankW+1)'(NumBanks));
      q_r = q_c + Aw'(1);
    end else begin
      r_r = r_rsum[BankW-1:0];
      q_r = q_c;
    end

    col_ext = StrideW'(col_c);
    // first and last pixel columns and the first row of centres pass through
    interior_c = (row_c != RowW'(1)) && (col_ext >= StrideW'(c_eff))
              && (col_ext < (stride - StrideW'(c_eff)));
    emit0_c    = row_c != '0;
    emit1_c    = HeightW'(row_c) == (h_eff - HeightW'(1));
    fe_c       = col_ext == (stride - StrideW'(1));

    // advance
    col_inc = col_ext + StrideW'(1);
    row_inc = {1'b0, row_c} + (RowW+1)'(1);
    if (col_inc >= stride) begin
      col_d = '0;
      bq_d  = '0;
      br_d  = '0;
      row_d = (HeightW'(row_inc) >= h_eff) ? '0 : row_inc[RowW-1:0];
    end else begin
      col_d = col_inc[ColW-1:0];
      row_d = row_c;
      if (r_c == BankW'(NumBanks - 1)) begin
        br_d = '0;
        bq_d = q_c + Aw'(1);
      end else begin
        br_d = r_c + BankW'(1);
        bq_d = q_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      bq_q  <= '0;
      br_q  <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      bq_q  <= bq_d;
      br_q  <= br_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // line store: two row halves picked by row parity, five banks each
  // the current half is read at the centre position (two rows up) and
  // written with the new sample; the other half gives centre, left and right
  // ---------------------------------------------------------------------------
  logic [Aw-1:0]      raddr [NumBanks];
  logic [SampleW-1:0] rdata [2][NumBanks];

  always_comb begin
    for (int b = 0; b < NumBanks; b++) begin
      if (r_c == BankW'(b)) begin
        raddr[b] = q_c;
      end else if (r_l == BankW'(b)) begin
        raddr[b] = q_l;
      end else begin
        raddr[b] = q_r;
      end
    end
  end

  for (genvar h = 0; h < 2; h++) begin : g_half
    for (genvar b = 0; b < NumBanks; b++) begin : g_bank
      logic we;
      assign we = in_fire && (row_c[0] == 1'(h)) && (r_c == BankW'(b));

      sbf_ram #(
        .Depth (BankDepth),
        .Width (SampleW)
      ) u_bank (
        .clk_i   (clk_i),
        .we_i    (we),
        .waddr_i (q_c),
        .wdata_i (sample_in_i),
        .re_i    (free1),
        .raddr_i (raddr[b]),
        .rdata_o (rdata[h][b])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: store data is back, form the cross stencil and the blend sum
  // ---------------------------------------------------------------------------
  logic [SampleW-1:0] s1_sample_q;
  logic               s1_par_q;
  logic [BankW-1:0]   s1_rc_q, s1_rl_q, s1_rr_q;
  logic               s1_interior_q, s1_emit0_q, s1_emit1_q, s1_fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (free1) begin
      v1_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sample_q   <= sample_in_i;
      s1_par_q      <= row_c[0];
      s1_rc_q       <= r_c;
      s1_rl_q       <= r_l;
      s1_rr_q       <= r_r;
      s1_interior_q <= interior_c;
      s1_emit0_q    <= emit0_c;
      s1_emit1_q    <= emit1_c;
      s1_fe_q       <= fe_c;
    end
  end

  logic [SampleW-1:0] centre, up, left, right, sharp;
  logic [SampleW+2:0] five_c;
  logic [SampleW+1:0] neigh_sum;
  logic signed [SampleW+3:0] lap;
  logic [BlendW-1:0]  blend_sum;

  always_comb begin
    centre = rdata[~s1_par_q][s1_rc_q];
    up     = rdata[s1_par_q][s1_rc_q];
    left   = rdata[~s1_par_q][s1_rl_q];
    right  = rdata[~s1_par_q][s1_rr_q];

    five_c    = {1'b0, centre, 2'b00} + (SampleW+3)'(centre);
    neigh_sum = (SampleW+2)'(up) + (SampleW+2)'(s1_sample_q)
              + (SampleW+2)'(left) + (SampleW+2)'(right);
    lap       = $signed({1'b0, five_c}) - $signed({2'b00, neigh_sum});

    // a border sample blends with itself, which gives the centre back exactly
    if (!s1_interior_q) begin
      sharp = centre;
    end else if (lap < 0) begin
      sharp = '0;
    end else if (lap > (SampleW+4)'(SampleMax)) begin
      sharp = SampleW'(SampleMax);
    end else begin
      sharp = lap[SampleW-1:0];
    end

    blend_sum = BlendW'(wgt_eff) * BlendW'(sharp)
              + BlendW'(WeightW'(PercentFull) - wgt_eff) * BlendW'(centre);
  end

  // ---------------------------------------------------------------------------
  // stage 2: blend sum held, divided by 100 on the way to the output register
  // ---------------------------------------------------------------------------
  logic [BlendW-1:0]  s2_sum_q;
  logic [SampleW-1:0] s2_sample_q;
  logic               s2_emit0_q, s2_emit1_q, s2_fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (free2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && free2) begin
      s2_sum_q    <= blend_sum;
      s2_sample_q <= s1_sample_q;
      s2_emit0_q  <= s1_emit0_q;
      s2_emit1_q  <= s1_emit1_q;
      s2_fe_q     <= s1_fe_q;
    end
  end

  logic [Div100W-1:0] div_prod;
  logic [SampleW-1:0] blend_res;

  assign div_prod  = Div100W'(s2_sum_q) * Div100W'(Div100Mul);
  assign blend_res = div_prod[Div100Shift +: SampleW];

  // ---------------------------------------------------------------------------
  // output register: up to two results per sample, the blended one first
  // ---------------------------------------------------------------------------
  logic               pend0_d, pend1_d;
  logic [SampleW-1:0] res_q, echo_q;
  logic               fe_q;

  always_comb begin
    pend0_d = pend0_q;
    pend1_d = pend1_q;
    if (out_fire) begin
      if (pend0_q) begin
        pend0_d = 1'b0;
      end else begin
        pend1_d = 1'b0;
      end
    end
    if (v2_q && free3) begin
      pend0_d = s2_emit0_q;
      pend1_d = s2_emit1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend0_q <= 1'b0;
      pend1_q <= 1'b0;
    end else begin
      pend0_q <= pend0_d;
      pend1_q <= pend1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && free3) begin
      res_q  <= blend_res;
      echo_q <= s2_sample_q;
      fe_q   <= s2_fe_q;
    end
  end

  assign sample_out_o = pend0_q ? res_q : echo_q;
  assign frame_end_o  = !pend0_q && fe_q;
  assign run_last_o   = pend0_q ? !pend1_q : 1'b1;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_stall_has_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v1_q)
    else $error("input stalled with an empty first stage");

  a_pair_drains_in_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && pend0_q && pend1_q |=> !pend0_q && pend1_q)
    else $error("second result lost after the first transfer");

  a_stage2_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !free3 |=> v2_q && $stable(s2_sum_q))
    else $error("stalled stage dropped its item");

  a_frame_end_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> run_last_o && !pend0_q)
    else $error("frame end on a blended result");

endmodule
